FILE: hdl/dds_tone_generator_top_assert.svh
// ---------------------------------------------------------------------------
// dds tone generator assertion macros
// shared property wrappers on clk_i / rst_ni
// ---------------------------------------------------------------------------
`ifndef DDS_TONE_GENERATOR_TOP_ASSERT_SVH
`define DDS_TONE_GENERATOR_TOP_ASSERT_SVH

// same-cycle implication
`define DTG_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define DTG_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/dtg_pkg.sv
// ---------------------------------------------------------------------------
// dtg_pkg
// types, constants and the sine table builder of the dds tone generator
// ---------------------------------------------------------------------------
package dtg_pkg;

  localparam int unsigned PhaseBitsDef     = 32;
  localparam int unsigned TableAddrBitsDef = 8;
  localparam int unsigned MaxFramesDef     = 64;

  localparam int unsigned FrameCountW = 7;
  localparam int unsigned TuningW     = 31;
  localparam int unsigned PeakW       = 15;
  localparam int unsigned SampleW     = 16;
  localparam int unsigned CfgIndexW   = 2;
  localparam int unsigned CfgDataW    = 31;

  localparam logic [CfgIndexW-1:0] CfgWaveShape  = 2'd0;
  localparam logic [CfgIndexW-1:0] CfgTuningWord = 2'd1;
  localparam logic [CfgIndexW-1:0] CfgPeakLevel  = 2'd2;

  localparam logic [TuningW-1:0] TuningReset = 31'd42852281;
  localparam logic [PeakW-1:0]   FullScale   = 15'd32767;

  // pi/2 in q30
  localparam logic [63:0] HalfPiQ30 = 64'd1686629713;
  // taylor denominators (2n)(2n+1), n = 1..7
  localparam logic [63:0] TaylorDiv [7] = '{64'd6, 64'd20, 64'd42, 64'd72,
                                            64'd110, 64'd156, 64'd210};

  typedef struct packed {
    logic [FrameCountW-1:0] frame_count;
    logic                   restart;
  } dtg_in_t;

  typedef struct packed {
    logic signed [SampleW-1:0] sample;
    logic                      last;
  } dtg_out_t;

  typedef struct packed {
    logic clear;   // zero the phase
    logic issue;   // launch one sample and step the phase
    logic last;    // launched sample ends the request
  } dtg_cmd_t;

  typedef struct packed {
    logic adv;     // pipeline moves this cycle
  } dtg_stat_t;

  // quarter-wave entry k of 2^addr_bits, q0.15, via fixed point taylor series
  function automatic logic [PeakW-1:0] sine_entry(int unsigned k, int unsigned addr_bits);
    logic [63:0]    x;
    logic [63:0]    term;
    longint         sum;
    longint         scaled;
    x    = (64'(k) * HalfPiQ30) >> addr_bits;
    term = x;
    sum  = longint'(x);
    for (int n = 1; n <= 7; n++) begin
      term = (term * x) >> 30;
      term = (term * x) >> 30;
      term = term / TaylorDiv[n-1];
      if ((n % 2) == 1) begin
        sum = sum - longint'(term);
      end else begin
        sum = sum + longint'(term);
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    scaled = (sum * 32767 + (64'sd1 <<< 29)) >>> 30;
    if (scaled > 32767) begin
      scaled = 32767;
    end
    return PeakW'(scaled);
  endfunction

endpackage

FILE: hdl/dtg_ctrl.sv
// ---------------------------------------------------------------------------
// dtg_ctrl
// request controller: takes requests, issues one sample per unstalled cycle
// ---------------------------------------------------------------------------
module dtg_ctrl import dtg_pkg::*; #(
  parameter int unsigned MAX_FRAMES = MaxFramesDef
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [FrameCountW-1:0] frame_count_i,
  input  logic                   restart_i,
  input  dtg_stat_t              stat_i,
  output dtg_cmd_t               cmd_o
);

  localparam int unsigned CntW = $clog2(MAX_FRAMES + 1);

  typedef enum logic [1:0] {
    StIdle = 2'b01,
    StRun  = 2'b10
  } dtg_state_e;

  dtg_state_e       state_q, state_d;
  logic [CntW-1:0]  frames_left_q, frames_left_d;
  logic [CntW-1:0]  sat_count;

  // clamp the request length
  always_comb begin
    if (frame_count_i > FrameCountW'(MAX_FRAMES)) begin
      sat_count = CntW'(MAX_FRAMES);
    end else begin
      sat_count = CntW'(frame_count_i);
    end
  end

  always_comb begin
    state_d       = state_q;
    frames_left_d = frames_left_q;
    cmd_o         = '0;
    in_ready_o    = 1'b0;
    unique case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.clear = restart_i;
          if (sat_count != '0) begin
            frames_left_d = sat_count;
            state_d       = StRun;
          end
        end
      end
      StRun: begin
        if (stat_i.adv) begin
          cmd_o.issue   = 1'b1;
          cmd_o.last    = (frames_left_q == CntW'(1));
          frames_left_d = frames_left_q - CntW'(1);
          if (frames_left_q == CntW'(1)) begin
            state_d = StIdle;
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= StIdle;
      frames_left_q <= '0;
    end else begin
      state_q       <= state_d;
      frames_left_q <= frames_left_d;
    end
  end

`include "dds_tone_generator_top_assert.svh"

  `DTG_ASSERT_NEXT(a_accept_loads_count, in_valid_i && in_ready_o && (sat_count != '0), (state_q == StRun) && (frames_left_q == $past(sat_count)), "request not loaded")
  `DTG_ASSERT_NEXT(a_last_ends_run, cmd_o.issue && cmd_o.last, state_q == StIdle, "run did not end on last sample")
  `DTG_ASSERT_SAME(a_run_has_frames, state_q == StRun, frames_left_q != '0, "running with no frames left")

endmodule

FILE: hdl/dtg_datapath.sv
// ---------------------------------------------------------------------------
// dtg_datapath
// config registers, phase accumulator, sine rom and scaling pipeline
// ---------------------------------------------------------------------------
module dtg_datapath import dtg_pkg::*; #(
  parameter int unsigned PHASE_BITS      = PhaseBitsDef,
  parameter int unsigned TABLE_ADDR_BITS = TableAddrBitsDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  input  logic [CfgIndexW-1:0] cfg_index_i,
  input  logic [CfgDataW-1:0]  cfg_data_i,
  input  dtg_cmd_t             cmd_i,
  output dtg_stat_t            stat_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output dtg_out_t             out_data_o
);

  localparam int unsigned Depth = (1 << TABLE_ADDR_BITS) + 1;
  localparam int unsigned RomW  = TABLE_ADDR_BITS + 1;
  localparam int unsigned SumW  = (PHASE_BITS > TuningW) ? PHASE_BITS : TuningW;
  localparam int unsigned ProdW = 2 * PeakW;

  // config registers
  logic                  wave_shape_q;
  logic [TuningW-1:0]    tuning_word_q;
  logic [PeakW-1:0]      peak_level_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wave_shape_q  <= 1'b0;
      tuning_word_q <= TuningReset;
      peak_level_q  <= FullScale;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CfgWaveShape: begin
          wave_shape_q <= cfg_data_i[0];
        end
        CfgTuningWord: begin
          if (cfg_data_i[TuningW-1:0] != '0) begin
            tuning_word_q <= cfg_data_i[TuningW-1:0];
          end
        end
        CfgPeakLevel: begin
          peak_level_q <= cfg_data_i[PeakW-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // phase accumulator
  logic [PHASE_BITS-1:0] phase_q;
  logic [SumW-1:0]       phase_sum;

  assign phase_sum = SumW'(phase_q) + SumW'(tuning_word_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= '0;
    end else begin
      if (cmd_i.clear) begin
        phase_q <= '0;
      end else if (cmd_i.issue) begin
        phase_q <= phase_sum[PHASE_BITS-1:0];
      end
    end
  end

  // quarter-wave sine rom
  logic [PeakW-1:0] sine_rom [Depth];

  for (genvar k = 0; k < Depth; k++) begin : g_rom
    localparam logic [PeakW-1:0] Entry = sine_entry(k, TABLE_ADDR_BITS);
    assign sine_rom[k] = Entry;
  end

  logic [1:0]                 quad;
  logic [TABLE_ADDR_BITS-1:0] idx;
  logic [RomW-1:0]            rom_addr;
  logic [PeakW-1:0]           mag;

  assign quad     = phase_q[PHASE_BITS-1 -: 2];
  assign idx      = phase_q[PHASE_BITS-3 -: TABLE_ADDR_BITS];
  assign rom_addr = quad[0] ? (RomW'(1 << TABLE_ADDR_BITS) - {1'b0, idx}) : {1'b0, idx};
  assign mag      = wave_shape_q ? FullScale : sine_rom[rom_addr];

  // stall pipeline: all stages move together
  logic adv;
  assign adv        = !out_valid_o || out_ready_i;
  assign stat_o.adv = adv;

  logic             s1_valid_q, s2_valid_q;
  logic [PeakW-1:0] s1_mag_q;
  logic             s1_neg_q, s1_last_q;
  logic [ProdW-1:0] s2_prod_q;
  logic             s2_neg_q, s2_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_o <= 1'b0;
    end else if (adv) begin
      s1_valid_q  <= cmd_i.issue;
      s2_valid_q  <= s1_valid_q;
      out_valid_o <= s2_valid_q;
    end
  end

  // divide by 32767: q = p >> 15 is low by at most one
  logic [PeakW-1:0]   quo_est;
  logic [PeakW+1:0]   rem_est;
  logic [PeakW-1:0]   quo;
  logic [SampleW-1:0] quo_ext;

  assign quo_est = s2_prod_q[ProdW-1 -: PeakW];
  assign rem_est = (PeakW+2)'(s2_prod_q[PeakW-1:0]) + (PeakW+2)'(quo_est);
  assign quo     = (rem_est >= (PeakW+2)'(FullScale)) ? quo_est + PeakW'(1) : quo_est;
  assign quo_ext = {1'b0, quo};

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_mag_q          <= mag;
      s1_neg_q          <= quad[1];
      s1_last_q         <= cmd_i.last;
      s2_prod_q         <= ProdW'(s1_mag_q) * ProdW'(peak_level_q);
      s2_neg_q          <= s1_neg_q;
      s2_last_q         <= s1_last_q;
      out_data_o.sample <= s2_neg_q ? -$signed(quo_ext) : $signed(quo_ext);
      out_data_o.last   <= s2_last_q;
    end
  end

`include "dds_tone_generator_top_assert.svh"

  `DTG_ASSERT_SAME(a_sample_in_range, out_valid_o, out_data_o.sample != 16'sh8000, "sample out of range")

endmodule

FILE: hdl/dds_tone_generator_top.sv
// ---------------------------------------------------------------------------
// dds_tone_generator_top
// phase accumulator tone generator, sine or square, scaled by peak level
// ---------------------------------------------------------------------------
// a request's samples pass from the issue loop through the s1, s2 and output registers, which stall together
// a request of n frames gets one sample per unstalled cycle from the issue loop
// the request port reopens once the last sample of a request is issued
// reset: async active low; phase 0, sine, tuning 42852281, peak 32767, no transaction pending
module dds_tone_generator_top import dtg_pkg::*; #(
  parameter int unsigned PHASE_BITS      = PhaseBitsDef,
  parameter int unsigned TABLE_ADDR_BITS = TableAddrBitsDef,
  parameter int unsigned MAX_FRAMES      = MaxFramesDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // request channel
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  dtg_in_t              in_data_i,
  // sample channel
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output dtg_out_t             out_data_o,
  // config write channel
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CfgIndexW-1:0] cfg_index_i,
  input  logic [CfgDataW-1:0]  cfg_data_i
);

  dtg_cmd_t  cmd;
  dtg_stat_t stat;

  // config writes are always taken; they must only be issued while idle (unchecked)
  assign cfg_ready_o = 1'b1;

  // controller: one transaction in, frame counter, one issue per pipeline step
  dtg_ctrl #(
    .MAX_FRAMES (MAX_FRAMES)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .frame_count_i (in_data_i.frame_count),
    .restart_i     (in_data_i.restart),
    .stat_i        (stat),
    .cmd_o         (cmd)
  );

  // datapath: phase, rom lookup, multiply, divide by full scale, output register
  dtg_datapath #(
    .PHASE_BITS      (PHASE_BITS),
    .TABLE_ADDR_BITS (TABLE_ADDR_BITS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule
